### design/dtsg_pkg.sv
package dtsg_pkg;

  // default parameter values
  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF     = 16;

  // fixed field widths
  localparam int STEP_W     = 32;
  localparam int AMP_W      = 15;
  localparam int SEG_W      = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int SINE_W     = 16;   // signed q15 sine
  localparam int ROM_W      = 15;   // unsigned table entry
  localparam int FRAC_BITS  = 15;

  // register reset values
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;
  localparam logic [SEG_W-1:0] SEG_RESET = 24'd8000;

  // pi/2 in q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP_A  = 8'd0,
    CFG_PHASE_STEP_B  = 8'd1,
    CFG_AMPLITUDE     = 8'd2,
    CFG_SEGMENT_LEN   = 8'd3
  } cfg_reg_t;

  // quarter-wave table entry, q30 taylor series to the x^13 term
  function automatic logic [ROM_W-1:0] q15_sine_of(input int unsigned idx,
                                                   input int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      scaled;
    x    = (64'(idx) * HALF_PI_Q30) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    scaled = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    return ROM_W'(scaled);
  endfunction

endpackage

### design/dtsg_ram.sv
module dtsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/dual_tone_sine_generator.sv
// Two-tone sine source: every input transfer on the s_ side yields one output
// transfer carrying amplitude * (sin A + sin B) saturated to SAMPLE_BITS, with
// tlast on the final sample of each segment and tuser[0] set when the sum
// clipped. One sample per clock is sustained while the output is not stalled;
// each tick passes through stage a, stage b and the output register. The rate
// is set by the read-modify-write of the phase/segment state, which lives in a
// one-entry synchronous RAM read every cycle, with the last written value forwarded
// over the registered read. The state entry has a valid flag cleared by reset,
// so no clearing pass is needed. Configuration writes are taken at any time
// (cfg_ready is always high) but must only be issued while no sample is in flight.
module dual_tone_sine_generator #(
  parameter int PHASE_BITS      = dtsg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = dtsg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = dtsg_pkg::SAMPLE_BITS_DEF,
  localparam int OUT_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtsg_pkg::CFG_DATA_W-1:0] cfg_data,
  // input ticks
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] restart
  // output samples
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_DATA_W-1:0]           m_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                            m_tlast,   // last_in_segment
  output logic [0:0]                      m_tuser    // [0] clipped
);

  import dtsg_pkg::*;

  localparam int N       = 1 << TABLE_ADDR_BITS;
  localparam int IDX_W   = TABLE_ADDR_BITS + 1;
  localparam int ST_W    = 2 * PHASE_BITS + SEG_W;
  localparam int SUM_W   = SINE_W + 1;
  localparam int PROD_W  = SUM_W + AMP_W + 1;
  localparam int EXT_W   = 26;
  localparam logic signed [EXT_W-1:0] SMAX = EXT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [EXT_W-1:0] SMIN = -SMAX - EXT_W'(1);

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_a;
    logic [PHASE_BITS-1:0] phase_b;
    logic [SEG_W-1:0]      sample_index;
  } nco_state_t;

  // configuration registers
  logic [PHASE_BITS-1:0] phase_step_a;
  logic [PHASE_BITS-1:0] phase_step_b;
  logic [AMP_W-1:0]      amplitude;
  logic [SEG_W-1:0]      segment_length;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step_a   <= '0;
      phase_step_b   <= '0;
      amplitude      <= AMP_RESET;
      segment_length <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP_A: phase_step_a   <= PHASE_BITS'(cfg_data);
        CFG_PHASE_STEP_B: phase_step_b   <= PHASE_BITS'(cfg_data);
        CFG_AMPLITUDE:    amplitude      <= cfg_data[AMP_W-1:0];
        CFG_SEGMENT_LEN:  segment_length <= cfg_data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine table, built at elaboration
  logic [ROM_W-1:0] sine_rom [N+1];

  for (genvar gi = 0; gi <= N; gi++) begin : g_rom
    assign sine_rom[gi] = q15_sine_of(gi, TABLE_ADDR_BITS);
  end

  function automatic logic signed [SINE_W-1:0] sine_lookup(
    input logic [PHASE_BITS-1:0] phase
  );
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] addr;
    logic [IDX_W-1:0]           idx;
    logic signed [SINE_W-1:0]   mag;
    quad = phase[PHASE_BITS-1 -: 2];
    addr = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    idx  = quad[0] ? (IDX_W'(N) - {1'b0, addr}) : {1'b0, addr};
    mag  = signed'({1'b0, sine_rom[idx]});
    return quad[1] ? -mag : mag;
  endfunction

  // pipeline handshake
  logic a_v, b_v;
  logic out_ready, b_ready, a_ready, s_accept;

  assign out_ready = !m_tvalid || m_tready;
  assign b_ready   = !b_v || out_ready;
  assign a_ready   = !a_v || b_ready;
  assign s_tready  = !rst && a_ready;
  assign s_accept  = s_tvalid && s_tready;

  // state memory with write forwarding
  nco_state_t st_rdata, st_wdata, st_wdata_q, state_cur, state_eff;
  logic       st_we, fwd_hit, state_valid, seg_last;
  logic [SEG_W:0] index_inc;

  dtsg_ram #(
    .WIDTH (ST_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (1'b0),
    .wdata (st_wdata),
    .raddr (1'b0),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit     <= 1'b0;
      state_valid <= 1'b0;
    end else begin
      fwd_hit <= st_we;
      if (st_we) state_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_wdata_q <= st_wdata;
  end

  // state update for the accepted tick
  always_comb begin
    if (!state_valid) state_cur = '0;
    else if (fwd_hit) state_cur = st_wdata_q;
    else              state_cur = st_rdata;
    state_eff = s_tdata[0] ? nco_state_t'('0) : state_cur;
    index_inc = {1'b0, state_eff.sample_index} + (SEG_W + 1)'(1);
    seg_last  = index_inc >= {1'b0, segment_length};
    st_we     = s_accept;
    if (seg_last) begin
      st_wdata = '0;
    end else begin
      st_wdata.phase_a      = state_eff.phase_a + phase_step_a;
      st_wdata.phase_b      = state_eff.phase_b + phase_step_b;
      st_wdata.sample_index = index_inc[SEG_W-1:0];
    end
  end

  // stage a: table lookups
  logic signed [SINE_W-1:0] a_sin_a, a_sin_b;
  logic                     a_last;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (a_ready) a_v <= s_accept;
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_sin_a <= sine_lookup(state_eff.phase_a);
      a_sin_b <= sine_lookup(state_eff.phase_b);
      a_last  <= seg_last;
    end
  end

  // stage b: sum and amplitude scaling
  logic signed [SUM_W-1:0]  sine_sum;
  logic signed [PROD_W-1:0] b_prod;
  logic                     b_last;

  assign sine_sum = SUM_W'(a_sin_a) + SUM_W'(a_sin_b);

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (b_ready) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_prod <= PROD_W'(sine_sum) * signed'({{(PROD_W-AMP_W){1'b0}}, amplitude});
      b_last <= a_last;
    end
  end

  // output stage: divide toward zero and saturate
  logic signed [PROD_W-1:0]    prod_adj;
  logic signed [EXT_W-1:0]     quot;
  logic signed [SAMPLE_BITS-1:0] sat_sample;
  logic                        sat_clip;

  always_comb begin
    prod_adj = b_prod + (b_prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    quot     = EXT_W'(prod_adj >>> FRAC_BITS);
    if (quot > SMAX) begin
      sat_sample = SAMPLE_BITS'(SMAX);
      sat_clip   = 1'b1;
    end else if (quot < SMIN) begin
      sat_sample = SAMPLE_BITS'(SMIN);
      sat_clip   = 1'b1;
    end else begin
      sat_sample = SAMPLE_BITS'(quot);
      sat_clip   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_ready) m_tvalid <= b_v;
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_tdata    <= OUT_DATA_W'(unsigned'(sat_sample));
      m_tlast    <= b_last;
      m_tuser[0] <= sat_clip;
    end
  end

`ifndef ASSERT_OFF
  // reset leaves the state reading as zero
  a_reset_state: assert property (@(posedge clk)
    rst |=> state_cur == nco_state_t'('0))
    else $error("state not zero after reset");

  // a segment end restarts phases and count for the next tick
  a_last_restart: assert property (@(posedge clk) disable iff (rst)
    s_accept && seg_last |=> state_cur == nco_state_t'('0))
    else $error("state not cleared after last sample");

  // a clipped sample sits at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata[SAMPLE_BITS-1:0] == SAMPLE_BITS'(SMAX) ||
       m_tdata[SAMPLE_BITS-1:0] == SAMPLE_BITS'(SMIN)))
    else $error("clipped sample not saturated");

  // forwarded state is exactly what was written the cycle before
  a_forward: assert property (@(posedge clk) disable iff (rst)
    st_we |=> (fwd_hit && state_cur == $past(st_wdata)))
    else $error("forwarding path lost the written state");
`endif

endmodule
